// File: src/spps_pkg.sv
// shared types, constants and helpers of the stepper position loop
package spps_pkg;

    // field widths
    localparam int ANGLE_W   = 32;
    localparam int SPEED_W   = 24;
    localparam int GAIN_W    = 24;
    localparam int US_W      = 16;
    localparam int WIDE_W    = 41;

    // serial multiplier: a operand, b operand shifted out one bit per cycle
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 24;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 5;

    // serial divider: one quotient bit per cycle
    localparam int DIV_N_W   = 72;
    localparam int DIV_D_W   = 37;
    localparam int DIV_CNT_W = 7;

    // constant divisors and limits
    localparam logic [DIV_D_W-1:0] INTEG_DIVISOR = 37'd65536000000;
    localparam logic [DIV_D_W-1:0] USEC_DIVISOR  = 37'd1000000;
    localparam logic [MUL_B_W-1:0] DERIV_SCALE   = 24'd15625;
    localparam logic [14:0]        DT_MIN_US     = 15'd1000;
    localparam logic [14:0]        DT_MAX_US     = 15'd20000;
    localparam logic [SPEED_W-1:0] DEADBAND_CODE = 24'd65;

    // register indexes
    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_ACCEL  = 3'd3;
    localparam logic [2:0] REG_SPEED  = 3'd4;
    localparam logic [2:0] REG_USTEP  = 3'd5;
    localparam logic [2:0] REG_FLAGS  = 3'd6;

    // register reset values
    localparam logic [31:0] ACCEL_RESET = 32'd3276800;
    localparam logic [22:0] SPEED_RESET = 23'd327680;
    localparam logic [31:0] USTEP_RESET = 32'd8433226;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT,
        ST_PULSE,
        ST_ENA,
        ST_ERR,
        ST_IMUL,
        ST_IMUL2,
        ST_IDIV,
        ST_PMUL,
        ST_DMUL,
        ST_DMUL2,
        ST_DDIV,
        ST_AMUL,
        ST_ADIV,
        ST_SLEW,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] n;
        logic [DIV_D_W-1:0] d;
    } div_req_t;

    // saturate a wide signed value to the angle width
    function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [WIDE_W-1:0] x);
        if (x > 41'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -41'sd2147483648)
            return 32'sh80000000;
        else
            return $signed(x[ANGLE_W-1:0]);
    endfunction

    // magnitude of a wide signed value
    function automatic logic [WIDE_W-1:0] mag_wide(input logic signed [WIDE_W-1:0] x);
        if (x[WIDE_W-1])
            return $unsigned(-x);
        else
            return $unsigned(x);
    endfunction

    // speeds inside the deadband read as zero
    function automatic logic [SPEED_W-1:0] pack_speed(input logic signed [SPEED_W-1:0] s);
        logic [SPEED_W-1:0] m;
        m = s[SPEED_W-1] ? $unsigned(-s) : $unsigned(s);
        if (m <= DEADBAND_CODE)
            return '0;
        else
            return $unsigned(s);
    endfunction

endpackage

// File: src/spps_mul.sv
// shift-add multiplier, one bit of the b operand per cycle
module spps_mul
    import spps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic [MUL_P_W-1:0] prod,
    output logic               done
);

    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_A_W-1:0]   hi_reg;
    logic [MUL_B_W-1:0]   lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_A_W:0]     sum;

    // partial product add for the current bit
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= MUL_CNT_W'(MUL_B_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_A_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign prod = {hi_reg, lo_reg};
    assign done = done_reg;

endmodule

// File: src/spps_div.sv
// restoring divider, one quotient bit per cycle
module spps_div
    import spps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic [DIV_N_W-1:0] quo,
    output logic               done
);

    logic [DIV_N_W-1:0]   n_reg;
    logic [DIV_D_W-1:0]   r_reg;
    logic [DIV_D_W-1:0]   d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     r_shift;
    logic [DIV_D_W:0]     r_diff;
    logic                 fits;

    // trial subtract
    assign r_shift = {r_reg, n_reg[DIV_N_W-1]};
    assign r_diff  = r_shift - {1'b0, d_reg};
    assign fits    = (r_shift >= {1'b0, d_reg});

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            n_reg <= req.n;
            r_reg <= '0;
            d_reg <= req.d;
        end
        else if (busy_reg)
        begin
            r_reg <= fits ? r_diff[DIV_D_W-1:0] : r_shift[DIV_D_W-1:0];
            n_reg <= {n_reg[DIV_N_W-2:0], fits};
        end
    end

    assign quo  = n_reg;
    assign done = done_reg;

endmodule

// File: src/stepper_position_pid_slew_top.sv
// top level of the closed-loop stepper position controller
// A full control tick runs up to seven products through the shared shift-add
// multiplier (one bit of a 24-bit operand per cycle) and up to three quotients through
// the shared restoring divider (one bit of a 72-bit dividend per cycle). One request is
// worked on at a time; a finished result waits in the output register while the next
// request is accepted. Registers sit on an APB port at byte address 4*index.
module stepper_position_pid_slew_top
    import spps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // request: elapsed_us[15:0], measured_angle[47:16], target_value[79:48],
    // pulse_count[95:80], direction_level[96], enable_level[97], zero fill
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    // command[0]
    input  logic         s_axis_tuser,
    // speed_out[23:0], drive_enabled[24], zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // configuration registers
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kd_reg;
    logic [31:0]       accel_reg;
    logic [22:0]       max_speed_reg;
    logic [31:0]       ustep_reg;
    logic [3:0]        flags_reg;

    // sequencer and loop state
    state_t                    state_reg, state_next;
    logic                      launched_reg, launched_next;
    logic signed [ANGLE_W-1:0] target_reg, target_next;
    logic signed [ANGLE_W-1:0] integ_reg, integ_next;
    logic signed [ANGLE_W-1:0] prev_reg, prev_next;
    logic signed [SPEED_W-1:0] last_reg, last_next;
    logic                      en_flag_reg, en_flag_next;

    // latched request and working values
    logic [US_W-1:0]           us_reg, us_next;
    logic signed [ANGLE_W-1:0] meas_reg, meas_next;
    logic [15:0]               pulse_reg, pulse_next;
    logic                      dir_reg, dir_next;
    logic                      enl_reg, enl_next;
    logic [ANGLE_W-1:0]        emag_reg, emag_next;
    logic                      eneg_reg, eneg_next;
    logic [ANGLE_W:0]          demag_reg, demag_next;
    logic                      deneg_reg, deneg_next;
    logic [DIV_N_W-1:0]        tmp_reg, tmp_next;
    logic signed [63:0]        vt_reg, vt_next;
    logic [26:0]               dv_reg, dv_next;
    logic [SPEED_W-1:0]        res_speed_reg, res_speed_next;
    logic                      res_en_reg, res_en_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]        out_speed_reg, out_speed_next;
    logic                      out_en_reg, out_en_next;

    // shared arithmetic units
    mul_req_t           mul_req;
    div_req_t           div_req;
    logic [MUL_P_W-1:0] mul_prod;
    logic               mul_done;
    logic [DIV_N_W-1:0] div_quo;
    logic               div_done;

    spps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    spps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .quo   (div_quo),
        .done  (div_done)
    );

    // configuration write and read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            accel_reg     <= ACCEL_RESET;
            max_speed_reg <= SPEED_RESET;
            ustep_reg     <= USTEP_RESET;
            flags_reg     <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_KP:    kp_reg        <= pwdata[GAIN_W-1:0];
                REG_KI:    ki_reg        <= pwdata[GAIN_W-1:0];
                REG_KD:    kd_reg        <= pwdata[GAIN_W-1:0];
                REG_ACCEL: accel_reg     <= pwdata;
                REG_SPEED: max_speed_reg <= pwdata[22:0];
                REG_USTEP: ustep_reg     <= pwdata;
                REG_FLAGS: flags_reg     <= pwdata[3:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_KP:    prdata = {8'd0, kp_reg};
            REG_KI:    prdata = {8'd0, ki_reg};
            REG_KD:    prdata = {8'd0, kd_reg};
            REG_ACCEL: prdata = accel_reg;
            REG_SPEED: prdata = {9'd0, max_speed_reg};
            REG_USTEP: prdata = ustep_reg;
            REG_FLAGS: prdata = {28'd0, flags_reg};
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // external step pulses move the target
    logic [ANGLE_W-1:0]        delta;
    logic                      back;
    logic signed [WIDE_W-1:0]  tgt_step;
    assign delta    = mul_prod[47:16];
    assign back     = flags_reg[1] & ~dir_reg;
    assign tgt_step = back ? (WIDE_W'(target_reg) - $signed({9'd0, delta}))
                           : (WIDE_W'(target_reg) + $signed({9'd0, delta}));

    // enable pin check
    logic active;
    assign active = flags_reg[3] ? ~enl_reg : enl_reg;

    // angle error and its change
    logic signed [ANGLE_W-1:0] err_sat;
    logic signed [WIDE_W-1:0]  de_wide;
    logic [WIDE_W-1:0]         em_wide;
    logic [WIDE_W-1:0]         dem_wide;
    assign err_sat  = sat_angle(WIDE_W'(target_reg) - WIDE_W'(meas_reg));
    assign de_wide  = WIDE_W'(err_sat) - WIDE_W'(prev_reg);
    assign em_wide  = mag_wide(WIDE_W'(err_sat));
    assign dem_wide = mag_wide(de_wide);

    // integral update
    logic signed [WIDE_W-1:0] iq;
    logic signed [ANGLE_W-1:0] integ_new;
    assign iq        = $signed({1'b0, div_quo[39:0]});
    assign integ_new = sat_angle(WIDE_W'(integ_reg) + (eneg_reg ? -iq : iq));

    // proportional and derivative terms, derivative saturates at 2^60
    logic signed [63:0] pterm;
    logic signed [63:0] dterm;
    logic signed [63:0] vt_p;
    logic signed [63:0] vt_d;
    assign pterm = $signed({25'd0, mul_prod[54:16]});
    assign dterm = (|div_quo[DIV_N_W-1:60]) ? 64'sh1000_0000_0000_0000
                                            : $signed({4'd0, div_quo[59:0]});
    assign vt_p  = (eneg_reg ? -pterm : pterm) + 64'(integ_reg);
    assign vt_d  = vt_reg + (deneg_reg ? -dterm : dterm);

    // slew time window
    logic [14:0] dte;
    assign dte = (us_reg < 16'(DT_MIN_US)) ? DT_MIN_US :
                 ((us_reg > 16'(DT_MAX_US)) ? DT_MAX_US : us_reg[14:0]);

    // slew limit and speed clamp
    logic signed [63:0] last_w;
    logic signed [63:0] dv_w;
    logic signed [63:0] lim_w;
    logic signed [63:0] dif_w;
    logic [63:0]        mvt;
    logic [63:0]        mlast;
    logic [63:0]        mdif;
    logic signed [63:0] cmd_slew;
    logic signed [63:0] cmd_clamp;
    assign last_w   = 64'(last_reg);
    assign dv_w     = $signed({37'd0, dv_reg});
    assign lim_w    = $signed({41'd0, max_speed_reg});
    assign dif_w    = vt_reg - last_w;
    assign mvt      = vt_reg[63] ? $unsigned(-vt_reg) : $unsigned(vt_reg);
    assign mlast    = last_w[63] ? $unsigned(-last_w) : $unsigned(last_w);
    assign mdif     = dif_w[63] ? $unsigned(-dif_w) : $unsigned(dif_w);
    assign cmd_slew = ((mvt > mlast) && (mdif > $unsigned(dv_w)))
                      ? ((vt_reg > last_w) ? (last_w + dv_w) : (last_w - dv_w))
                      : vt_reg;
    assign cmd_clamp = (cmd_slew > lim_w) ? lim_w :
                       ((cmd_slew < -lim_w) ? -lim_w : cmd_slew);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            target_reg    <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            last_reg      <= '0;
            en_flag_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            target_reg    <= target_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            last_reg      <= last_next;
            en_flag_reg   <= en_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        us_reg        <= us_next;
        meas_reg      <= meas_next;
        pulse_reg     <= pulse_next;
        dir_reg       <= dir_next;
        enl_reg       <= enl_next;
        emag_reg      <= emag_next;
        eneg_reg      <= eneg_next;
        demag_reg     <= demag_next;
        deneg_reg     <= deneg_next;
        tmp_reg       <= tmp_next;
        vt_reg        <= vt_next;
        dv_reg        <= dv_next;
        res_speed_reg <= res_speed_next;
        res_en_reg    <= res_en_next;
        out_speed_reg <= out_speed_next;
        out_en_reg    <= out_en_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        target_next    = target_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        en_flag_next   = en_flag_reg;
        us_next        = us_reg;
        meas_next      = meas_reg;
        pulse_next     = pulse_reg;
        dir_next       = dir_reg;
        enl_next       = enl_reg;
        emag_next      = emag_reg;
        eneg_next      = eneg_reg;
        demag_next     = demag_reg;
        deneg_next     = deneg_reg;
        tmp_next       = tmp_reg;
        vt_next        = vt_reg;
        dv_next        = dv_reg;
        res_speed_next = res_speed_reg;
        res_en_next    = res_en_reg;
        out_speed_next = out_speed_reg;
        out_en_next    = out_en_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mul_req        = '0;
        div_req        = '0;
        s_axis_tready  = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    us_next    = s_axis_tdata[15:0];
                    meas_next  = $signed(s_axis_tdata[47:16]);
                    pulse_next = s_axis_tdata[95:80];
                    dir_next   = s_axis_tdata[96];
                    enl_next   = s_axis_tdata[97];
                    if (s_axis_tuser == CMD_LOAD)
                    begin
                        target_next    = $signed(s_axis_tdata[79:48]);
                        res_speed_next = pack_speed(last_reg);
                        res_en_next    = en_flag_reg;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_EXT;
                    end
                end
            end
            ST_EXT:
            begin
                if (flags_reg[0] && (pulse_reg != '0))
                    state_next = ST_PULSE;
                else
                    state_next = ST_ENA;
            end
            ST_PULSE:
            begin
                mul_req.a = {32'd0, ustep_reg};
                mul_req.b = {8'd0, pulse_reg};
                if (!launched_reg)
                begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    target_next   = sat_angle(tgt_step);
                    state_next    = ST_ENA;
                end
            end
            ST_ENA:
            begin
                state_next = ST_ERR;
                if (flags_reg[0] && flags_reg[2])
                begin
                    if (!active)
                    begin
                        last_next      = '0;
                        en_flag_next   = 1'b0;
                        res_speed_next = '0;
                        res_en_next    = 1'b0;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        en_flag_next = 1'b1;
                    end
                end
            end
            ST_ERR:
            begin
                emag_next  = em_wide[ANGLE_W-1:0];
                eneg_next  = err_sat[ANGLE_W-1];
                demag_next = dem_wide[ANGLE_W:0];
                deneg_next = de_wide[WIDE_W-1];
                prev_next  = err_sat;
                state_next = ST_IMUL;
            end
            ST_IMUL:
            begin
                mul_req.a = {32'd0, emag_reg};
                mul_req.b = ki_reg;
                if (!launched_reg)
                begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    tmp_next      = mul_prod[DIV_N_W-1:0];
                    state_next    = ST_IMUL2;
                end
            end
            ST_IMUL2:
            begin
                mul_req.a = tmp_reg[MUL_A_W-1:0];
                mul_req.b = {8'd0, us_reg};
                if (!launched_reg)
                begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    tmp_next      = mul_prod[DIV_N_W-1:0];
                    state_next    = ST_IDIV;
                end
            end
            ST_IDIV:
            begin
                div_req.n = tmp_reg;
                div_req.d = INTEG_DIVISOR;
                if (!launched_reg)
                begin
                    div_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    integ_next    = integ_new;
                    state_next    = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                mul_req.a = {32'd0, emag_reg};
                mul_req.b = kp_reg;
                if (!launched_reg)
                begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    vt_next       = vt_p;
                    state_next    = (us_reg != '0) ? ST_DMUL : ST_AMUL;
                end
            end
            ST_DMUL:
            begin
                mul_req.a = {31'd0, demag_reg};
                mul_req.b = kd_reg;
                if (!launched_reg)
                begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    tmp_next      = mul_prod[DIV_N_W-1:0];
                    state_next    = ST_DMUL2;
                end
            end
            ST_DMUL2:
            begin
                mul_req.a = tmp_reg[MUL_A_W-1:0];
                mul_req.b = DERIV_SCALE;
                if (!launched_reg)
                begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    tmp_next      = mul_prod[DIV_N_W-1:0];
                    state_next    = ST_DDIV;
                end
            end
            ST_DDIV:
            begin
                div_req.n = tmp_reg;
                div_req.d = {11'd0, us_reg, 10'd0};
                if (!launched_reg)
                begin
                    div_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    vt_next       = vt_d;
                    state_next    = ST_AMUL;
                end
            end
            ST_AMUL:
            begin
                mul_req.a = {32'd0, accel_reg};
                mul_req.b = {9'd0, dte};
                if (!launched_reg)
                begin
                    mul_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_done)
                begin
                    launched_next = 1'b0;
                    tmp_next      = mul_prod[DIV_N_W-1:0];
                    state_next    = ST_ADIV;
                end
            end
            ST_ADIV:
            begin
                div_req.n = tmp_reg;
                div_req.d = USEC_DIVISOR;
                if (!launched_reg)
                begin
                    div_req.start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    dv_next       = div_quo[26:0];
                    state_next    = ST_SLEW;
                end
            end
            ST_SLEW:
            begin
                last_next      = cmd_clamp[SPEED_W-1:0];
                res_speed_next = pack_speed(cmd_clamp[SPEED_W-1:0]);
                res_en_next    = en_flag_reg;
                state_next     = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_speed_next = res_speed_reg;
                    out_en_next    = res_en_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_en_reg, out_speed_reg};

endmodule

// File: src/spps_checker.sv
// port-level checks of the stepper position loop, bound to the top level
module spps_props
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // speed clamp keeps the most negative code out
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:0] != 24'h800000)
        else $error("speed beyond clamp");

    // deadband speeds read as zero
    a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:0] == 24'd0)
                       || ($signed(m_axis_tdata[23:0]) > 24'sd65)
                       || ($signed(m_axis_tdata[23:0]) < -24'sd65))
        else $error("speed inside deadband");

endmodule

bind stepper_position_pid_slew_top spps_props u_spps_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/spps_checker.sv
// checker for the stepper position loop: tracks registers, predicts speed, compares results
`timescale 1ns / 100ps

module spps_checker
    import spps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           err_count,
    output int           pending
);

    typedef struct {
        logic [SPEED_W-1:0] speed;
        logic               enabled;
    } speed_result_t;

    localparam longint PROD_LIMIT = 64'sh1000_0000_0000_0000;

    speed_result_t expected_speeds[$];

    // register copies
    longint kp, ki, kd, accel, speed_cap, ustep;
    logic [3:0] ext_flags;

    // loop state
    longint target, integ, prev_err, cur_speed;
    logic   drive_on;

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint absval(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint capped_product(input longint a, input longint b);
        longint p;
        p = a * b;
        return (p > PROD_LIMIT) ? PROD_LIMIT : p;
    endfunction

    function automatic logic [SPEED_W-1:0] deadband(input longint s);
        logic [SPEED_W-1:0] r;
        r = s[SPEED_W-1:0];
        return (absval(s) <= 65) ? '0 : r;
    endfunction

    // one control step or target load
    function automatic speed_result_t speed_step(input logic cmd, input logic [103:0] d);
        speed_result_t res;
        longint us, meas, pulses, delta, err, emag, pm, phi, plo, vt;
        longint dlen, de, qa, qb, t, dte, dv, next_speed, lim;
        logic neg, back, active;
        us     = longint'(d[15:0]);
        meas   = longint'($signed(d[47:16]));
        pulses = longint'(d[95:80]);
        if (cmd == CMD_LOAD) begin
            target = longint'($signed(d[79:48]));
            res.speed = deadband(cur_speed);
            res.enabled = drive_on;
            return res;
        end
        // external step and enable inputs
        if (ext_flags[0]) begin
            if (pulses != 0) begin
                back = ext_flags[1] && !d[96];
                delta = (pulses * ustep) >>> 16;
                target = clamp32(back ? target - delta : target + delta);
            end
            if (ext_flags[2]) begin
                active = ext_flags[3] ? !d[97] : d[97];
                if (!active) begin
                    cur_speed = 0;
                    drive_on = 1'b0;
                    res.speed = '0;
                    res.enabled = 1'b0;
                    return res;
                end
                drive_on = 1'b1;
            end
        end
        err  = clamp32(target - meas);
        neg  = err < 0;
        emag = absval(err);
        // integral term
        pm  = capped_product(emag, ki);
        phi = pm >>> 16;
        plo = pm & 64'hFFFF;
        pm  = (phi * us + ((plo * us) >>> 16)) / 1000000;
        integ = clamp32(integ + (neg ? -pm : pm));
        // proportional term
        pm = capped_product(emag, kp) >>> 16;
        vt = (neg ? -pm : pm) + integ;
        // derivative term, skipped when no time elapsed
        if (us != 0) begin
            dlen = us * 1024;
            de = err - prev_err;
            pm = capped_product(absval(de), kd);
            qa = pm / dlen;
            qb = pm % dlen;
            if (qa > PROD_LIMIT / 15625)
                t = PROD_LIMIT;
            else
                t = qa * 15625 + (qb * 15625) / dlen;
            if (t > PROD_LIMIT)
                t = PROD_LIMIT;
            vt += (de < 0) ? -t : t;
        end
        prev_err = err;
        // acceleration limit on a rise in magnitude
        dte = (us < 1000) ? 1000 : ((us > 20000) ? 20000 : us);
        dv = (accel * dte) / 1000000;
        if (absval(vt) > absval(cur_speed) && absval(vt - cur_speed) > dv)
            next_speed = (vt > cur_speed) ? cur_speed + dv : cur_speed - dv;
        else
            next_speed = vt;
        lim = (speed_cap > 8388607) ? 8388607 : speed_cap;
        if (next_speed > lim)
            next_speed = lim;
        if (next_speed < -lim)
            next_speed = -lim;
        cur_speed = next_speed;
        res.speed = deadband(cur_speed);
        res.enabled = drive_on;
        return res;
    endfunction

    assign pending = expected_speeds.size();

    // register snoop, prediction on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        speed_result_t got, exp_r;
        if (!rst_n) begin
            kp = 0;
            ki = 0;
            kd = 0;
            accel = longint'(ACCEL_RESET);
            speed_cap = longint'(SPEED_RESET);
            ustep = longint'(USTEP_RESET);
            ext_flags = '0;
            target = 0;
            integ = 0;
            prev_err = 0;
            cur_speed = 0;
            drive_on = 1'b1;
            expected_speeds.delete();
            err_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_KP:    kp = longint'(pwdata[23:0]);
                    REG_KI:    ki = longint'(pwdata[23:0]);
                    REG_KD:    kd = longint'(pwdata[23:0]);
                    REG_ACCEL: accel = longint'(pwdata);
                    REG_SPEED: speed_cap = longint'(pwdata[22:0]);
                    REG_USTEP: ustep = longint'(pwdata);
                    REG_FLAGS: ext_flags = pwdata[3:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.speed = m_axis_tdata[23:0];
                got.enabled = m_axis_tdata[24];
                if (expected_speeds.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result speed %h enabled %b", $time,
                             got.speed, got.enabled);
                end else begin
                    exp_r = expected_speeds.pop_front();
                    if (got.speed !== exp_r.speed) begin
                        err_count++;
                        $display("%0t: speed_out expected %h actual %h", $time,
                                 exp_r.speed, got.speed);
                    end
                    if (got.enabled !== exp_r.enabled) begin
                        err_count++;
                        $display("%0t: drive_enabled expected %b actual %b", $time,
                                 exp_r.enabled, got.enabled);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_speeds.push_back(speed_step(s_axis_tuser, s_axis_tdata));
        end
    end

endmodule

// File: dv/tb_stepper_position_pid_slew_top.sv
// testbench top: clock, reset, register setup, request stimulus and verdict
`timescale 1ns / 100ps

module tb_stepper_position_pid_slew_top;
    import spps_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           err_count;
    int           pending;

    int burst_left = 0;
    int gap_max = 10;
    int idle_cycles = 0;
    int hold_cycles = 0;
    int stall_mode = 0;
    int stall_run = 0;
    int center = 0;

    always #5 clk = ~clk;

    stepper_position_pid_slew_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    spps_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .err_count(err_count), .pending(pending)
    );

    // result side stall pattern: free running, coin flips, or long runs
    always @(posedge clk)
    begin
        hold_cycles++;
        if (hold_cycles >= 300) begin
            hold_cycles = 0;
            stall_mode = $urandom_range(0, 2);
        end
        if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_mode == 1)
            m_axis_tready <= $urandom_range(0, 1);
        else if (stall_run == 0) begin
            stall_run = $urandom_range(1, 25);
            m_axis_tready <= ~m_axis_tready;
        end else
            stall_run--;
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_stepper_position_pid_slew_top: errors");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_request(input logic cmd, input logic [15:0] us, input logic [31:0] meas,
                                input logic [31:0] tgt, input logic [15:0] pulses,
                                input logic dir, input logic ena);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'b0, ena, dir, pulses, tgt, meas, us};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic tick(input logic [15:0] us, input logic [31:0] meas,
                        input logic [15:0] pulses, input logic dir, input logic ena);
        send_request(CMD_TICK, us, meas, '0, pulses, dir, ena);
    endtask

    // random register setting; extremes on the first two phases
    task automatic random_setup(input int phase);
        logic [31:0] v;
        if (phase == 0) begin
            reg_write(REG_KP, 32'hFFFFFF);
            reg_write(REG_KI, 32'hFFFFFF);
            reg_write(REG_KD, 32'hFFFFFF);
            reg_write(REG_ACCEL, 32'hFFFFFFFF);
            reg_write(REG_SPEED, 32'h7FFFFF);
        end else if (phase == 1) begin
            reg_write(REG_KP, 32'd1);
            reg_write(REG_KI, 32'd0);
            reg_write(REG_KD, 32'd0);
            reg_write(REG_ACCEL, 32'd0);
            reg_write(REG_SPEED, 32'd0);
        end else begin
            reg_write(REG_KP, $urandom_range(0, 32'hFFFFFF) >> $urandom_range(0, 20));
            reg_write(REG_KI, $urandom_range(0, 32'hFFFFFF) >> $urandom_range(0, 23));
            reg_write(REG_KD, $urandom_range(0, 32'hFFFFFF) >> $urandom_range(0, 23));
            reg_write(REG_ACCEL, $urandom() >> $urandom_range(0, 24));
            reg_write(REG_SPEED, $urandom_range(0, 32'h7FFFFF) >> $urandom_range(0, 8));
        end
        v = $urandom();
        reg_write(REG_USTEP, v >> $urandom_range(0, 31));
        reg_write(REG_FLAGS, $urandom_range(0, 15));
    endtask

    initial
    begin
        logic [15:0] us;
        logic [31:0] meas;
        int sel;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturation, zero and huge elapsed time, deadband
        gap_max = 3;
        reg_write(REG_KP, 32'h10000);
        reg_write(REG_KI, 32'h100);
        reg_write(REG_KD, 32'h100);
        send_request(CMD_LOAD, 16'd0, '0, 32'h7FFFFFFF, '0, 1'b1, 1'b1);
        tick(16'd1000, 32'h80000000, 16'd0, 1'b0, 1'b0);
        tick(16'd0, 32'h80000000, 16'd0, 1'b0, 1'b0);
        tick(16'd65535, 32'h00000000, 16'hFFFF, 1'b1, 1'b1);
        send_request(CMD_LOAD, 16'hFFFF, 32'hFFFFFFFF, 32'h80000000, 16'hFFFF, 1'b1, 1'b1);
        tick(16'd1, 32'h7FFFFFFF, 16'd0, 1'b0, 1'b0);
        send_request(CMD_LOAD, 16'd0, '0, 32'd0, '0, 1'b0, 1'b0);
        tick(16'd1000, 32'd0, 16'd0, 1'b0, 1'b0);
        tick(16'd1000, 32'd40, 16'd0, 1'b0, 1'b0);
        drain();

        // external mode: pulse direction, enable active high then low, target overflow
        reg_write(REG_USTEP, 32'hFFFFFFFF);
        reg_write(REG_FLAGS, 32'h7);
        reg_write(REG_SPEED, 32'h7FFFFF);
        reg_write(REG_ACCEL, 32'hFFFFFFFF);
        tick(16'd1000, 32'd0, 16'hFFFF, 1'b1, 1'b1);
        tick(16'd1000, 32'd0, 16'hFFFF, 1'b1, 1'b1);
        tick(16'd1000, 32'd0, 16'hFFFF, 1'b0, 1'b1);
        tick(16'd1000, 32'd0, 16'd5, 1'b1, 1'b0);
        send_request(CMD_LOAD, 16'd0, '0, 32'h12345, '0, 1'b0, 1'b0);
        tick(16'd20000, 32'd0, 16'd0, 1'b1, 1'b1);
        drain();
        reg_write(REG_FLAGS, 32'hF);
        tick(16'd1000, 32'd0, 16'd3, 1'b1, 1'b1);
        tick(16'd1000, 32'd0, 16'd3, 1'b1, 1'b0);
        drain();
        reg_write(REG_FLAGS, 32'h1);
        tick(16'd1000, 32'd0, 16'd100, 1'b0, 1'b0);
        drain();
        reg_write(REG_ACCEL, 32'd0);
        reg_write(REG_SPEED, 32'd0);
        tick(16'd500, 32'h00010000, 16'd0, 1'b0, 1'b0);
        drain();

        // random phases, each on its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            random_setup(phase);
            gap_max = (phase % 3 == 2) ? 0 : $urandom_range(1, 40);
            for (int n = 0; n < 190; n++) begin
                sel = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0: us = 16'd0;
                    1: us = $urandom_range(0, 16'hFFFF);
                    2: us = $urandom_range(1, 999);
                    3: us = $urandom_range(20000, 16'hFFFF);
                    default: us = $urandom_range(900, 1100);
                endcase
                meas = center + $urandom_range(0, 1 << $urandom_range(1, 20)) - 32'h8000;
                if (sel < 5)
                    send_request($urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
                else if (sel < 15) begin
                    center = $signed($urandom()) >>> $urandom_range(0, 31);
                    send_request(CMD_LOAD, us, meas, center, $urandom(), $urandom_range(0, 1),
                                 $urandom_range(0, 1));
                end else
                    tick(us, meas, (sel < 60) ? 16'd0 : $urandom_range(0, 40),
                         $urandom_range(0, 1), (sel % 8) != 0);
                if (n == 95)
                    drain();
            end
        end

        drain();
        repeat (500) @(posedge clk);
        if (err_count == 0)
            $display("tb_stepper_position_pid_slew_top: clean");
        else
            $display("tb_stepper_position_pid_slew_top: errors");
        $finish;
    end

endmodule

// File: filelist.f
src/spps_pkg.sv
src/spps_mul.sv
src/spps_div.sv
src/stepper_position_pid_slew_top.sv
src/spps_checker.sv
dv/spps_checker.sv
dv/tb_stepper_position_pid_slew_top.sv
